@@ sv/delimited_frame_receiver_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the delimited frame receiver
// Each macro expands to one concurrent assertion clocked on the rising edge
// and disabled while reset is high. Defining ASSERT_OFF removes them all.
// ---------------------------------------------------------------------------
`ifndef DELIMITED_FRAME_RECEIVER_ASSERT_SVH
`define DELIMITED_FRAME_RECEIVER_ASSERT_SVH

`ifndef ASSERT_OFF

// The condition must hold at every clock edge outside reset.
`define DFR_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: invariant violated");

// When the trigger holds, the consequence must hold at the next edge.
`define DFR_ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define DFR_ASSERT_ALWAYS(label, clk, rst, cond)
`define DFR_ASSERT_NEXT(label, clk, rst, trig, cons)

`endif

`endif

@@ sv/dfr_pkg.sv @@
// ---------------------------------------------------------------------------
// dfr_pkg
// Types, codes and the CRC-16/ARC byte update shared by the delimited frame
// receiver modules.
// ---------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

   // Configuration register indexes.
   localparam logic [7:0] REG_START_DELIMITER  = 8'd0;
   localparam logic [7:0] REG_END_DELIMITER    = 8'd1;
   localparam logic [7:0] REG_MAX_FRAME_LENGTH = 8'd2;
   localparam logic [7:0] REG_CRC_CHECK_ENABLE = 8'd3;

   // Register reset values.
   localparam logic [7:0] START_DELIMITER_RESET  = 8'h02;
   localparam logic [7:0] END_DELIMITER_RESET    = 8'h03;
   localparam logic [7:0] MAX_FRAME_LENGTH_RESET = 8'd255;

   // Framing constants.
   localparam logic [7:0]  MIN_FRAME_LENGTH = 8'd4;
   localparam logic [15:0] CRC_POLY_REFL    = 16'hA001;
   localparam logic [15:0] CRC_INIT         = 16'h0000;

   // Result kinds.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   typedef enum logic [1:0] {
      LINK_NOSYNC = 2'd0,
      LINK_SYNC   = 2'd1,
      LINK_FRAME  = 2'd2
   } link_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_CRC_ERROR = 3'd2,
      ST_NO_END    = 3'd3,
      ST_LINE_ERR  = 3'd4
   } status_type;

   // Live configuration seen by the parser.
   typedef struct packed {
      logic [7:0] start_delimiter;
      logic [7:0] end_delimiter;
      logic [7:0] max_frame_length;
      logic       crc_check_enable;
   } cfg_type;

   // One result from the parser.
   typedef struct packed {
      logic       valid;
      logic       kind;
      logic [7:0] payload_byte;
      logic [7:0] frame_address;
      status_type status;
   } result_type;

   // CRC-16/ARC update over one byte, reflected polynomial, bit at a time.
   function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ sv/dfr_csr.sv @@
// ---------------------------------------------------------------------------
// dfr_csr
// Configuration registers of the delimited frame receiver. Writes are
// always taken; an index beyond the register list is ignored.
// ---------------------------------------------------------------------------
`default_nettype none

module dfr_csr (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [7:0]    csr_index,
   input  wire logic [7:0]    csr_wdata,
   output dfr_pkg::cfg_type   cfg
);

   dfr_pkg::cfg_type cfg_ff;
   dfr_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index of a write request.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            dfr_pkg::REG_START_DELIMITER:  cfg_in.start_delimiter  = csr_wdata;
            dfr_pkg::REG_END_DELIMITER:    cfg_in.end_delimiter    = csr_wdata;
            dfr_pkg::REG_MAX_FRAME_LENGTH: cfg_in.max_frame_length = csr_wdata;
            dfr_pkg::REG_CRC_CHECK_ENABLE: cfg_in.crc_check_enable = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_delimiter  <= dfr_pkg::START_DELIMITER_RESET;
         cfg_ff.end_delimiter    <= dfr_pkg::END_DELIMITER_RESET;
         cfg_ff.max_frame_length <= dfr_pkg::MAX_FRAME_LENGTH_RESET;
         cfg_ff.crc_check_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/dfr_parser.sv @@
// ---------------------------------------------------------------------------
// dfr_parser
// Frame state and per-byte decision logic: sync hunt, length check, address
// capture, payload forwarding, CRC accumulation and the closing report.
// ---------------------------------------------------------------------------
`default_nettype none

`include "delimited_frame_receiver_assert.svh"

module dfr_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       rx_byte,
   input  wire logic             line_error,
   input  wire dfr_pkg::cfg_type cfg,
   output dfr_pkg::result_type   result
);

   dfr_pkg::link_type link_ff, link_in;
   logic [7:0]        index_ff, index_in;
   logic [7:0]        length_ff, length_in;
   logic [7:0]        address_ff, address_in;
   logic [15:0]       crc_ff, crc_in;
   logic [15:0]       crc_rx_ff, crc_rx_in;
   logic [15:0]       crc_next;
   logic [8:0]        index_plus2;

   assign crc_next    = dfr_pkg::crc_arc_byte(crc_ff, rx_byte);
   assign index_plus2 = {1'b0, index_ff} + 9'd2;

   // Next state and result for the byte in the input register.
   always_comb begin
      link_in    = link_ff;
      index_in   = index_ff;
      length_in  = length_ff;
      address_in = address_ff;
      crc_in     = crc_ff;
      crc_rx_in  = crc_rx_ff;

      result               = '0;
      result.kind          = dfr_pkg::KIND_PAYLOAD;
      result.frame_address = address_ff;
      result.status        = dfr_pkg::ST_OK;

      if (line_error) begin
         link_in = dfr_pkg::LINK_NOSYNC;
         if (link_ff == dfr_pkg::LINK_FRAME) begin
            result.valid  = 1'b1;
            result.kind   = dfr_pkg::KIND_REPORT;
            result.status = dfr_pkg::ST_LINE_ERR;
         end
      end else begin
         case (link_ff)
            dfr_pkg::LINK_SYNC: begin
               if (rx_byte == cfg.start_delimiter) begin
                  link_in    = dfr_pkg::LINK_FRAME;
                  index_in   = '0;
                  length_in  = '0;
                  address_in = '0;
                  crc_in     = dfr_pkg::CRC_INIT;
                  crc_rx_in  = '0;
               end else begin
                  link_in = dfr_pkg::LINK_NOSYNC;
               end
            end
            dfr_pkg::LINK_FRAME: begin
               if (index_ff == '0) begin
                  // Length byte: range check, then it joins the CRC.
                  length_in = rx_byte;
                  if (!(rx_byte inside
                        {[dfr_pkg::MIN_FRAME_LENGTH : cfg.max_frame_length]})) begin
                     link_in = dfr_pkg::LINK_NOSYNC;
                  end else begin
                     crc_in   = crc_next;
                     index_in = 8'd1;
                  end
               end else if (index_ff < length_ff) begin
                  index_in = index_ff + 8'd1;
                  if (index_ff == 8'd1) begin
                     address_in = rx_byte;
                     crc_in     = crc_next;
                  end else if (index_plus2 < {1'b0, length_ff}) begin
                     crc_in              = crc_next;
                     result.valid        = 1'b1;
                     result.payload_byte = rx_byte;
                  end else begin
                     // Received CRC, high byte first.
                     crc_rx_in = {crc_rx_ff[7:0], rx_byte};
                  end
               end else if (rx_byte == cfg.end_delimiter) begin
                  link_in      = dfr_pkg::LINK_SYNC;
                  result.valid = 1'b1;
                  result.kind  = dfr_pkg::KIND_REPORT;
                  if (length_ff <= dfr_pkg::MIN_FRAME_LENGTH) begin
                     result.status = dfr_pkg::ST_EMPTY;
                  end else if (cfg.crc_check_enable && crc_ff != crc_rx_ff) begin
                     result.status = dfr_pkg::ST_CRC_ERROR;
                  end else begin
                     result.status = dfr_pkg::ST_OK;
                  end
               end else begin
                  link_in       = dfr_pkg::LINK_NOSYNC;
                  result.valid  = 1'b1;
                  result.kind   = dfr_pkg::KIND_REPORT;
                  result.status = dfr_pkg::ST_NO_END;
               end
            end
            default: begin
               // Unsynced: a start opens a frame, an end arms sync.
               if (rx_byte == cfg.start_delimiter) begin
                  link_in    = dfr_pkg::LINK_FRAME;
                  index_in   = '0;
                  length_in  = '0;
                  address_in = '0;
                  crc_in     = dfr_pkg::CRC_INIT;
                  crc_rx_in  = '0;
               end else if (rx_byte == cfg.end_delimiter) begin
                  link_in = dfr_pkg::LINK_SYNC;
               end else begin
                  link_in = dfr_pkg::LINK_NOSYNC;
               end
            end
         endcase
      end
   end

   // Frame state advances only when a request is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff    <= dfr_pkg::LINK_NOSYNC;
         index_ff   <= '0;
         length_ff  <= '0;
         address_ff <= '0;
         crc_ff     <= dfr_pkg::CRC_INIT;
         crc_rx_ff  <= '0;
      end else if (step) begin
         link_ff    <= link_in;
         index_ff   <= index_in;
         length_ff  <= length_in;
         address_ff <= address_in;
         crc_ff     <= crc_in;
         crc_rx_ff  <= crc_rx_in;
      end
   end

   `DFR_ASSERT_ALWAYS(a_index_in_frame, clock, reset, index_ff <= length_ff)
   `DFR_ASSERT_NEXT(a_line_error_drops_sync, clock, reset, step && line_error,
                    link_ff == dfr_pkg::LINK_NOSYNC)
   `DFR_ASSERT_NEXT(a_payload_stays_in_frame, clock, reset,
                    step && result.valid && result.kind == dfr_pkg::KIND_PAYLOAD,
                    link_ff == dfr_pkg::LINK_FRAME)
   `DFR_ASSERT_NEXT(a_report_closes_frame, clock, reset,
                    step && result.valid && result.kind == dfr_pkg::KIND_REPORT,
                    link_ff != dfr_pkg::LINK_FRAME)

endmodule

`default_nettype wire

@@ sv/delimited_frame_receiver.sv @@
// ---------------------------------------------------------------------------
// delimited_frame_receiver
// Receives UART bytes, finds start/end delimited frames with a length byte,
// an address and a CRC-16/ARC, forwards payload bytes and reports each
// frame's outcome.
//
// Usage:
//   Request channel (req_): one received byte and its line-error flag per
//   request, taken when req_valid is high and req_stall low.
//   Response channel (rsp_): a payload byte (kind 0) or a frame end report
//   (kind 1) with the frame address and a status code. Many requests, such
//   as start delimiters, length, address and CRC bytes, give no response.
//   Configuration (csr_): index and data, always ready; write only while
//   the block is idle.
//   A request accepted into the input register is processed when the
//   response register is free or drains; its response, if any, is then
//   registered. One request per cycle is sustained while rsp_stall is low;
//   frame state and CRC update are combinational between the two registers.
//   When the downstream stalls, the response register holds its item and
//   the input register still takes one more request before req_stall rises.
//   Reset is synchronous: both registers empty, link unsynced, registers at
//   start 0x02, end 0x03, maximum length 255 and CRC check off.
// ---------------------------------------------------------------------------
`default_nettype none

module delimited_frame_receiver (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_line_error,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [7:0]       rsp_frame_address,
   output logic [2:0]       rsp_status,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   dfr_pkg::cfg_type    cfg;
   dfr_pkg::result_type result;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_error_ff;
   logic       out_valid_ff, out_valid_in;
   logic       out_kind_ff;
   logic [7:0] out_payload_ff;
   logic [7:0] out_address_ff;
   logic [2:0] out_status_ff;
   logic       advance;
   logic       step;
   logic       take;

   // The held request moves on when the response register is free or drains.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = advance ? (step && result.valid) : out_valid_ff;

   dfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .line_error (in_error_ff),
      .cfg        (cfg),
      .result     (result)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff  <= req_rx_byte;
         in_error_ff <= req_line_error;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.valid) begin
         out_kind_ff    <= result.kind;
         out_payload_ff <= result.payload_byte;
         out_address_ff <= result.frame_address;
         out_status_ff  <= result.status;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_payload_byte  = out_payload_ff;
   assign rsp_frame_address = out_address_ff;
   assign rsp_status        = out_status_ff;

endmodule

`default_nettype wire

@@ test/tb_delimited_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// Delimited frame receiver testbench
// A short byte table walks the receiver through sync, good, empty, truncated,
// unterminated and line-error frames. Random framed traffic then runs under
// several delimiter, length and CRC settings. Responses are checked against
// typed table rows or an in-bench frame parser; both channels get random gaps.
// ----------------------------------------------------------------------------
module tb_delimited_frame_receiver;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 600000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 225;
   localparam int MAX_WAIT        = 16;

   // One response of the receiver: a payload byte or an end-of-frame report.
   typedef struct packed {
      logic                name_kind;
      logic [7:0]          payload;
      logic [7:0]          address;
      dfr_pkg::status_type status;
   } frame_event_type;

   // One directed request; typed rows carry their own expected response.
   typedef struct packed {
      logic [7:0]      rx;
      logic            line_err;
      logic            typed;
      logic            yields;
      frame_event_type ev;
   } vector_row_type;

   localparam frame_event_type NO_EVENT =
      '{dfr_pkg::KIND_PAYLOAD, 8'h00, 8'h00, dfr_pkg::ST_OK};

   // Default delimiters are 0x02 (start) and 0x03 (end), CRC check off.
   localparam vector_row_type DIRECTED_VECTORS [27] = '{
      // Line error before any sync gives nothing.
      '{8'h00, 1'b1, 1'b1, 1'b0, NO_EVENT},
      // Frame of length 5 with one payload byte, closed properly.
      '{8'h02, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'h05, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'hA5, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'hFF, 1'b0, 1'b1, 1'b1, '{dfr_pkg::KIND_PAYLOAD, 8'hFF, 8'hA5, dfr_pkg::ST_OK}},
      '{8'h12, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'h34, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'h03, 1'b0, 1'b1, 1'b1, '{dfr_pkg::KIND_REPORT, 8'h00, 8'hA5, dfr_pkg::ST_OK}},
      // Start straight from sync, minimum length: empty payload.
      '{8'h02, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'h04, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'h03, 1'b0, 1'b1, 1'b1, '{dfr_pkg::KIND_REPORT, 8'h00, 8'h00, dfr_pkg::ST_EMPTY}},
      // Length byte below the minimum drops the frame silently.
      '{8'h02, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'h03, 1'b0, 1'b1, 1'b0, NO_EVENT},
      // Delimiter value as payload, then a wrong closing byte.
      '{8'h02, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'h05, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'h02, 1'b0, 1'b1, 1'b1, '{dfr_pkg::KIND_PAYLOAD, 8'h02, 8'hFF, dfr_pkg::ST_OK}},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'h02, 1'b0, 1'b1, 1'b1, '{dfr_pkg::KIND_REPORT, 8'h00, 8'hFF, dfr_pkg::ST_NO_END}},
      // Line error in the middle of a frame.
      '{8'h02, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'h07, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'h3C, 1'b0, 1'b0, 1'b0, NO_EVENT},
      '{8'h00, 1'b1, 1'b1, 1'b1,
        '{dfr_pkg::KIND_REPORT, 8'h00, 8'h3C, dfr_pkg::ST_LINE_ERR}}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_line_error = 1'b0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_frame_address;
   logic [2:0] rsp_status;

   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_index = 8'h00;
   logic [7:0] csr_wdata = 8'h00;

   // Parser mirror: configuration and frame state.
   dfr_pkg::cfg_type  cfg;
   dfr_pkg::link_type link;
   logic [7:0]        byte_pos;
   logic [7:0]        frame_len;
   logic [7:0]        frame_addr;
   logic [15:0]       crc_run;
   logic [15:0]       crc_seen;
   logic [15:0]       arc_lut [256];

   frame_event_type events_due [$];

   int mismatches = 0;
   int cycle_count = 0;
   int sent_count = 0;
   bit burst_tx = 1'b0;
   bit burst_rx = 1'b0;
   int hold_rx = 0;

   delimited_frame_receiver dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .req_line_error    (req_line_error),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_frame_address (rsp_frame_address),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #1 clock = ~clock;

   // Table-driven CRC-16/ARC, one byte per lookup.
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      return (crc >> 8) ^ arc_lut[crc[7:0] ^ b];
   endfunction

   task automatic reset_model();
      cfg = '{dfr_pkg::START_DELIMITER_RESET, dfr_pkg::END_DELIMITER_RESET,
              dfr_pkg::MAX_FRAME_LENGTH_RESET, 1'b0};
      link = dfr_pkg::LINK_NOSYNC;
      byte_pos = 8'd0;
      frame_len = 8'd0;
      frame_addr = 8'd0;
      crc_run = dfr_pkg::CRC_INIT;
      crc_seen = 16'h0000;
   endtask

   task automatic open_frame();
      link = dfr_pkg::LINK_FRAME;
      byte_pos = 8'd0;
      frame_len = 8'd0;
      frame_addr = 8'd0;
      crc_run = dfr_pkg::CRC_INIT;
      crc_seen = 16'h0000;
   endtask

   // Advance the parser mirror by one received byte and tell what comes out.
   task automatic parse_rx_byte(input logic [7:0] b, input logic err,
                                output bit emits, output frame_event_type ev);
      int pos_now;
      emits = 1'b0;
      ev = NO_EVENT;
      if (err) begin
         // A line error always drops sync; inside a frame it is reported.
         if (link == dfr_pkg::LINK_FRAME) begin
            emits = 1'b1;
            ev = '{dfr_pkg::KIND_REPORT, 8'h00, frame_addr, dfr_pkg::ST_LINE_ERR};
         end
         link = dfr_pkg::LINK_NOSYNC;
      end else if (link == dfr_pkg::LINK_SYNC) begin
         if (b == cfg.start_delimiter) begin
            open_frame();
         end else begin
            link = dfr_pkg::LINK_NOSYNC;
         end
      end else if (link != dfr_pkg::LINK_FRAME) begin
         if (b == cfg.start_delimiter) begin
            open_frame();
         end else if (b == cfg.end_delimiter) begin
            link = dfr_pkg::LINK_SYNC;
         end else begin
            link = dfr_pkg::LINK_NOSYNC;
         end
      end else if (byte_pos == 8'd0) begin
         // Length byte: out of range abandons the frame without a report.
         frame_len = b;
         if (!(b inside {[dfr_pkg::MIN_FRAME_LENGTH : cfg.max_frame_length]})) begin
            link = dfr_pkg::LINK_NOSYNC;
         end else begin
            crc_run = crc_step(crc_run, b);
            byte_pos = 8'd1;
         end
      end else if (byte_pos < frame_len) begin
         pos_now = int'(byte_pos);
         byte_pos = byte_pos + 8'd1;
         if (pos_now == 1) begin
            frame_addr = b;
            crc_run = crc_step(crc_run, b);
         end else if (pos_now + 2 < int'(frame_len)) begin
            crc_run = crc_step(crc_run, b);
            emits = 1'b1;
            ev = '{dfr_pkg::KIND_PAYLOAD, b, frame_addr, dfr_pkg::ST_OK};
         end else begin
            crc_seen = {crc_seen[7:0], b};
         end
      end else if (b == cfg.end_delimiter) begin
         // Closing delimiter: empty payload wins over a CRC mismatch.
         link = dfr_pkg::LINK_SYNC;
         emits = 1'b1;
         if (frame_len <= dfr_pkg::MIN_FRAME_LENGTH) begin
            ev = '{dfr_pkg::KIND_REPORT, 8'h00, frame_addr, dfr_pkg::ST_EMPTY};
         end else if (cfg.crc_check_enable && crc_run != crc_seen) begin
            ev = '{dfr_pkg::KIND_REPORT, 8'h00, frame_addr, dfr_pkg::ST_CRC_ERROR};
         end else begin
            ev = '{dfr_pkg::KIND_REPORT, 8'h00, frame_addr, dfr_pkg::ST_OK};
         end
      end else begin
         link = dfr_pkg::LINK_NOSYNC;
         emits = 1'b1;
         ev = '{dfr_pkg::KIND_REPORT, 8'h00, frame_addr, dfr_pkg::ST_NO_END};
      end
   endtask

   // Present one request after a random gap and wait until it is taken.
   task automatic offer_byte(input logic [7:0] b, input logic err,
                             output bit emits, output frame_event_type ev);
      int gap;
      if ($urandom_range(0, 49) == 0) burst_tx = !burst_tx;
      gap = burst_tx ? 0 : int'($urandom_range(0, MAX_WAIT));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_line_error <= err;
      do @(posedge clock); while (req_stall);
      parse_rx_byte(b, err, emits, ev);
      sent_count++;
   endtask

   task automatic feed_byte(input logic [7:0] b, input logic err);
      bit emits;
      frame_event_type ev;
      offer_byte(b, err, emits, ev);
      if (emits) events_due.push_back(ev);
   endtask

   // Drop the request line and wait until the receiver has drained.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (events_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [7:0] index, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         dfr_pkg::REG_START_DELIMITER:  cfg.start_delimiter = data;
         dfr_pkg::REG_END_DELIMITER:    cfg.end_delimiter = data;
         dfr_pkg::REG_MAX_FRAME_LENGTH: cfg.max_frame_length = data;
         dfr_pkg::REG_CRC_CHECK_ENABLE: cfg.crc_check_enable = data[0];
         default: ;
      endcase
   endtask

   task automatic program_link(input logic [7:0] start_d, input logic [7:0] end_d,
                               input logic [7:0] max_len, input logic crc_en);
      write_csr(dfr_pkg::REG_START_DELIMITER, start_d);
      write_csr(dfr_pkg::REG_END_DELIMITER, end_d);
      write_csr(dfr_pkg::REG_MAX_FRAME_LENGTH, max_len);
      write_csr(dfr_pkg::REG_CRC_CHECK_ENABLE, {7'd0, crc_en});
      csr_valid <= 1'b0;
   endtask

   // One framed burst with random content, sometimes broken on purpose.
   task automatic send_frame(input bit longest);
      logic [7:0]  body [$];
      logic [7:0]  len_b;
      logic [15:0] crc;
      int          pick;
      int          hi_len;
      int          err_at;

      // Occasional line noise between frames.
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            feed_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
         end
      end
      if ($urandom_range(0, 3) == 0) feed_byte(cfg.end_delimiter, 1'b0);
      feed_byte(cfg.start_delimiter, 1'b0);

      // Mostly short legal lengths; a few illegal, minimum and maximum ones.
      pick = int'($urandom_range(0, 99));
      hi_len = (cfg.max_frame_length < 8'd14) ? int'(cfg.max_frame_length) : 14;
      if (longest) begin
         len_b = cfg.max_frame_length;
      end else if (pick < 5) begin
         len_b = 8'($urandom_range(0, 3));
      end else if (pick < 10) begin
         len_b = (cfg.max_frame_length < 8'd255) ?
                 8'($urandom_range(int'(cfg.max_frame_length) + 1, 255)) :
                 8'($urandom_range(0, 3));
      end else if (pick < 11) begin
         len_b = cfg.max_frame_length;
      end else if (pick < 25) begin
         len_b = dfr_pkg::MIN_FRAME_LENGTH;
      end else begin
         len_b = 8'($urandom_range(5, hi_len));
      end

      feed_byte(len_b, 1'b0);
      if (!(len_b inside {[dfr_pkg::MIN_FRAME_LENGTH : cfg.max_frame_length]})) return;

      crc = crc_step(dfr_pkg::CRC_INIT, len_b);
      for (int i = 1; i + 2 < int'(len_b); i++) begin
         body.push_back(8'($urandom_range(0, 255)));
         crc = crc_step(crc, body[body.size() - 1]);
      end
      if ($urandom_range(0, 7) == 0) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
      body.push_back(crc[15:8]);
      body.push_back(crc[7:0]);
      body.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                     cfg.end_delimiter);

      err_at = ($urandom_range(0, 14) == 0) ? int'($urandom_range(0, body.size() - 1)) : -1;
      for (int i = 0; i < body.size(); i++) begin
         if (i == err_at) begin
            feed_byte(8'($urandom_range(0, 255)), 1'b1);
         end else begin
            feed_byte(body[i], 1'b0);
         end
      end
   endtask

   task automatic flag_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      mismatches++;
   endtask

   // Response side: check each taken response, then stall for a random gap.
   always @(posedge clock) begin : rsp_side
      frame_event_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_rx = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (events_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, %s %0d %0h %0h %0d",
                        $time, "actual kind/payload/address/status", rsp_kind,
                        rsp_payload_byte, rsp_frame_address, rsp_status);
               mismatches++;
            end else begin
               want = events_due.pop_front();
               if (rsp_kind !== want.name_kind) begin
                  flag_field("kind", {7'd0, want.name_kind}, {7'd0, rsp_kind});
               end
               if (rsp_payload_byte !== want.payload)
                  flag_field("payload_byte", want.payload, rsp_payload_byte);
               if (rsp_frame_address !== want.address)
                  flag_field("frame_address", want.address, rsp_frame_address);
               if (rsp_status !== want.status) begin
                  flag_field("status", {5'd0, want.status}, {5'd0, rsp_status});
               end
            end
            if ($urandom_range(0, 49) == 0) burst_rx = !burst_rx;
            hold_rx = burst_rx ? 0 : int'($urandom_range(0, MAX_WAIT));
         end
         if (hold_rx > 0) begin
            rsp_stall <= 1'b1;
            hold_rx--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL delimited_frame_receiver");
         $finish;
      end
   end

   initial begin : stimulus
      vector_row_type  row;
      bit              emits;
      frame_event_type ev;
      int              base;
      logic [15:0]     v;
      logic [7:0]      start_d;
      logic [7:0]      end_d;
      logic [7:0]      max_len;

      for (int i = 0; i < 256; i++) begin
         v = 16'(i);
         repeat (8) v = v[0] ? ((v >> 1) ^ dfr_pkg::CRC_POLY_REFL) : (v >> 1);
         arc_lut[i] = v;
      end
      reset_model();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed table at reset settings.
      for (int i = 0; i < $size(DIRECTED_VECTORS); i++) begin
         row = DIRECTED_VECTORS[i];
         offer_byte(row.rx, row.line_err, emits, ev);
         if (row.typed) begin
            if (row.yields) events_due.push_back(row.ev);
         end else if (emits) begin
            events_due.push_back(ev);
         end
      end
      wait_idle();

      // Random traffic, one register setting per phase.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: program_link(8'h00, 8'hFF, 8'd5, 1'b1);
            1: program_link(8'hFF, 8'h00, 8'd255, 1'b1);
            2: program_link(dfr_pkg::START_DELIMITER_RESET, dfr_pkg::END_DELIMITER_RESET,
                            dfr_pkg::MAX_FRAME_LENGTH_RESET, 1'b0);
            default: begin
               start_d = 8'($urandom_range(0, 255));
               end_d = ($urandom_range(0, 3) == 0) ? start_d : 8'($urandom_range(0, 255));
               max_len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(5, 255)) :
                         8'($urandom_range(5, 24));
               program_link(start_d, end_d, max_len, 1'($urandom_range(0, 1)));
            end
         endcase
         base = sent_count;
         send_frame(p == 1);
         while (sent_count - base < ITEMS_PER_PHASE) send_frame(1'b0);
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("PASS delimited_frame_receiver");
      end else begin
         $display("FAIL delimited_frame_receiver");
      end
      $finish;
   end

endmodule
